[src/assert_macros.svh]
// Assertion helpers shared by the converter RTL.
// Used by the queue, front end and back end; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define R2Y_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define R2Y_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[src/r2y_pkg.sv]
// Shared types, constants and arithmetic helpers of the RGB to YCbCr 4:2:0 converter.
// No dependencies; every other source file but assert_macros.svh imports it.
`default_nettype none

package r2y_pkg;

    localparam int FRAC_BITS = 12;
    localparam int IN_W      = 16;
    localparam int CH_W      = FRAC_BITS + 1;
    localparam int SUM_W     = CH_W + 3;
    localparam int LUM_W     = SUM_W + 16;
    localparam int YP_W      = LUM_W + 8;
    localparam int D_W       = LUM_W + 1;
    localparam int KC_W      = 25;
    localparam int P_W       = D_W + KC_W;
    localparam int YSHIFT    = 16 + FRAC_BITS + 3;
    localparam int CSHIFT    = 32 + FRAC_BITS + 3;
    localparam int YT_W      = YP_W - YSHIFT + 1;
    localparam int CH_ONE    = 1 << FRAC_BITS;
    localparam int POS_W     = 12;
    localparam int DIM_W     = 13;
    localparam int VAL_W     = 8;
    localparam int IDX_W     = 2;
    localparam int Q_DEPTH   = 4;
    localparam int QA_W      = $clog2(Q_DEPTH);

    localparam logic [LUM_W-1:0] KR = LUM_W'(13933);
    localparam logic [LUM_W-1:0] KG = LUM_W'(46871);
    localparam logic [LUM_W-1:0] KB = LUM_W'(4732);
    localparam logic [YP_W-1:0]  KY = YP_W'(219);
    localparam logic signed [KC_W-1:0] KCB = KC_W'(7911222);
    localparam logic signed [KC_W-1:0] KCR = KC_W'(9321859);
    localparam logic signed [P_W-1:0]  C_OFS = P_W'(128) <<< CSHIFT;

    localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(1920);
    localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(1080);
    localparam logic [DIM_W-1:0] HEIGHT_MAX = DIM_W'(4096);

    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = IDX_W'(1);

    typedef enum logic [1:0] {
        PLANE_Y  = 2'd0,
        PLANE_CB = 2'd1,
        PLANE_CR = 2'd2
    } t_plane;

    typedef struct packed {
        logic [CH_W-1:0] b;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] r;
    } t_rgb;

    typedef struct packed {
        logic [SUM_W-1:0] b;
        logic [SUM_W-1:0] g;
        logic [SUM_W-1:0] r;
    } t_sum;

    typedef struct packed {
        logic             is_chroma;
        logic             last;
        logic             done;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
    } t_meta;

    typedef struct packed {
        t_meta meta;
        t_sum  s;
    } t_job;

    typedef struct packed {
        t_plane           plane_sel;
        logic [VAL_W-1:0] sample_value;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic             last_of_item;
        logic             frame_done;
    } t_res;

    function automatic logic [CH_W-1:0] clamp_in(input logic signed [IN_W-1:0] v);
        logic [CH_W-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > IN_W'(CH_ONE)) begin
            res = CH_W'(CH_ONE);
        end else begin
            res = CH_W'(v);
        end
        return res;
    endfunction

    function automatic logic [DIM_W-1:0] eff_size(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] t;
        t = (v < DIM_W'(2)) ? DIM_W'(2) : v;
        t = (t > hi) ? hi : t;
        return {t[DIM_W-1:1], 1'b0};
    endfunction

    function automatic logic [SUM_W-1:0] sum6(input logic [CH_W-1:0] e0,
                                              input logic [CH_W-1:0] e1,
                                              input logic [CH_W-1:0] e2,
                                              input logic [CH_W-1:0] o0,
                                              input logic [CH_W-1:0] o1,
                                              input logic [CH_W-1:0] o2);
        return SUM_W'(e0) + (SUM_W'(e1) << 1) + SUM_W'(e2)
             + SUM_W'(o0) + (SUM_W'(o1) << 1) + SUM_W'(o2);
    endfunction

    function automatic logic [VAL_W-1:0] luma_val(input logic [YP_W-1:0] p);
        logic [YT_W-1:0] t;
        t = YT_W'(p >> YSHIFT) + YT_W'(16);
        return (t > YT_W'(255)) ? VAL_W'(255) : t[VAL_W-1:0];
    endfunction

    function automatic logic [VAL_W-1:0] chroma_val(input logic signed [P_W-1:0] p);
        logic signed [P_W-1:0] t;
        logic [P_W-1:0]        q;
        logic [VAL_W-1:0]      res;
        t = p + C_OFS;
        q = $unsigned(t) >> CSHIFT;
        if (t[P_W-1]) begin
            res = '0;
        end else if (q > P_W'(255)) begin
            res = VAL_W'(255);
        end else begin
            res = q[VAL_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[src/r2y_pix_if.sv]
// Pixel input channel: valid/ready handshake with one RGB pixel per beat.
// Depends on r2y_pkg.
`default_nettype none

interface r2y_pix_if;
    import r2y_pkg::*;

    logic                   valid;
    logic                   ready;
    logic signed [IN_W-1:0] red_in;
    logic signed [IN_W-1:0] green_in;
    logic signed [IN_W-1:0] blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    output ready);
endinterface

`default_nettype wire

[src/r2y_res_if.sv]
// Result output channel: valid/ready handshake with one component sample per beat.
// Depends on r2y_pkg.
`default_nettype none

interface r2y_res_if;
    import r2y_pkg::*;

    logic             valid;
    logic             ready;
    logic [1:0]       plane_sel;
    logic [VAL_W-1:0] sample_value;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic             last_of_item;
    logic             frame_done;

    modport source (output valid, output plane_sel, output sample_value, output pos_x,
                    output pos_y, output last_of_item, output frame_done, input ready);
    modport sink   (input valid, input plane_sel, input sample_value, input pos_x,
                    input pos_y, input last_of_item, input frame_done, output ready);
endinterface

`default_nettype wire

[src/r2y_cfg_if.sv]
// Configuration write channel: valid/ready handshake carrying register index and data.
// Depends on r2y_pkg.
`default_nettype none

interface r2y_cfg_if;
    import r2y_pkg::*;

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] index;
    logic [DIM_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[src/r2y_queue.sv]
// Short job queue between the pixel front end and the arithmetic back end.
// Depends on r2y_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module r2y_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  r2y_pkg::t_job i_data,
    output logic          o_full,
    input  logic          i_pop,
    output r2y_pkg::t_job o_data,
    output logic          o_empty
);
    import r2y_pkg::*;

    t_job            r_mem [Q_DEPTH];
    logic [QA_W-1:0] r_wp;
    logic [QA_W-1:0] r_rp;
    logic [QA_W:0]   r_cnt;

    assign o_full  = (r_cnt == (QA_W+1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QA_W'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QA_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (QA_W+1)'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - (QA_W+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    `R2Y_ASSERT(a_q_no_overflow, i_push |-> !o_full, "push into full queue")
    `R2Y_ASSERT(a_q_no_underflow, i_pop |-> !o_empty, "pop from empty queue")
    `R2Y_ASSERT(a_q_count_up, (i_push && !i_pop) |=> (r_cnt == $past(r_cnt) + 3'd1), "queue count did not advance")

endmodule

`default_nettype wire

[src/r2y_front.sv]
// Front end: takes pixels and configuration, keeps counters, history and the even-row store,
// and turns each pixel into a luma job plus, where chroma applies, a chroma job.
// Depends on r2y_pkg, the pixel and configuration interfaces and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module r2y_front #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    r2y_pix_if.sink       i_pix,
    r2y_cfg_if.sink       i_cfg,
    output logic          o_push,
    output r2y_pkg::t_job o_job,
    input  logic          i_full
);
    import r2y_pkg::*;

    localparam int WMAX = (MAX_WIDTH < 4096) ? MAX_WIDTH : 4096;
    localparam int AW   = (WMAX > 1) ? $clog2(WMAX) : 1;

    t_rgb             row_mem [WMAX];
    t_rgb             r_rd;
    logic             r_rd_ok;
    logic [DIM_W-1:0] r_wid;
    logic [DIM_W-1:0] r_hgt;
    logic [POS_W-1:0] r_col;
    logic [POS_W-1:0] r_row;
    logic [POS_W-1:0] n_col;
    logic [POS_W-1:0] n_row;
    t_rgb             r_hist1;
    t_rgb             r_hist2;
    t_rgb             r_ehist1;
    t_rgb             r_ehist2;
    logic             r_pend;
    t_job             r_pend_job;

    logic             accept;
    logic             cfg_hit;
    t_rgb             cur;
    t_rgb             e0;
    t_rgb             o0;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic             oor;
    logic             chroma;
    logic             wrap_x;
    logic             wrap_y;
    logic             last_px;
    logic             first_c;
    t_job             luma_job;
    t_job             chroma_job;
    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    wr_addr;

    assign i_pix.ready = r_rd_ok && !r_pend && !i_full;
    assign i_cfg.ready = 1'b1;
    assign accept      = i_pix.valid && i_pix.ready;
    assign cfg_hit     = i_cfg.valid &&
                         (i_cfg.index == REG_FRAME_WIDTH || i_cfg.index == REG_FRAME_HEIGHT);

    always_comb begin
        cur.r = clamp_in(i_pix.red_in);
        cur.g = clamp_in(i_pix.green_in);
        cur.b = clamp_in(i_pix.blue_in);

        oor = (DIM_W'(r_col) >= r_wid) || (DIM_W'(r_row) >= r_hgt);
        x   = oor ? '0 : r_col;
        y   = oor ? '0 : r_row;
        chroma  = x[0] && y[0] && !oor;
        wrap_x  = (DIM_W'(x) + DIM_W'(1)) >= r_wid;
        wrap_y  = (DIM_W'(y) + DIM_W'(1)) >= r_hgt;
        last_px = wrap_x && wrap_y && !oor;

        if (wrap_x) begin
            n_col = '0;
            n_row = wrap_y ? '0 : y + POS_W'(1);
        end else begin
            n_col = x + POS_W'(1);
            n_row = y;
        end

        first_c = (x == POS_W'(1));
        e0 = first_c ? r_ehist1 : r_ehist2;
        o0 = first_c ? r_hist1 : r_hist2;

        luma_job.meta.is_chroma = 1'b0;
        luma_job.meta.last      = !chroma;
        luma_job.meta.done      = !chroma && last_px;
        luma_job.meta.pos_x     = x;
        luma_job.meta.pos_y     = y;
        luma_job.s.r            = {cur.r, 3'b000};
        luma_job.s.g            = {cur.g, 3'b000};
        luma_job.s.b            = {cur.b, 3'b000};

        chroma_job.meta.is_chroma = 1'b1;
        chroma_job.meta.last      = 1'b1;
        chroma_job.meta.done      = last_px;
        chroma_job.meta.pos_x     = {1'b0, x[POS_W-1:1]};
        chroma_job.meta.pos_y     = {1'b0, y[POS_W-1:1]};
        chroma_job.s.r = sum6(e0.r, r_ehist1.r, r_rd.r, o0.r, r_hist1.r, cur.r);
        chroma_job.s.g = sum6(e0.g, r_ehist1.g, r_rd.g, o0.g, r_hist1.g, cur.g);
        chroma_job.s.b = sum6(e0.b, r_ehist1.b, r_rd.b, o0.b, r_hist1.b, cur.b);

        rd_addr = AW'(r_col);
        wr_addr = AW'(x);
    end

    assign o_push = (r_pend && !i_full) || accept;
    assign o_job  = r_pend ? r_pend_job : luma_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wid   <= eff_size(WIDTH_RST, DIM_W'(WMAX));
            r_hgt   <= HEIGHT_RST;
            r_col   <= '0;
            r_row   <= '0;
            r_hist1 <= '0;
            r_hist2 <= '0;
            r_rd_ok <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_rd_ok <= !(accept || cfg_hit);
            if (r_pend && !i_full) begin
                r_pend <= 1'b0;
            end
            if (accept) begin
                r_pend  <= chroma;
                r_hist2 <= r_hist1;
                r_hist1 <= cur;
                r_col   <= n_col;
                r_row   <= n_row;
            end
            if (cfg_hit) begin
                r_col <= '0;
                r_row <= '0;
                unique case (i_cfg.index)
                    REG_FRAME_WIDTH: begin
                        r_wid <= eff_size(i_cfg.data, DIM_W'(WMAX));
                    end
                    REG_FRAME_HEIGHT: begin
                        r_hgt <= eff_size(i_cfg.data, HEIGHT_MAX);
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ehist2   <= r_ehist1;
            r_ehist1   <= r_rd;
            r_pend_job <= chroma_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !y[0]) begin
            row_mem[wr_addr] <= cur;
        end
        r_rd <= row_mem[rd_addr];
    end

    `R2Y_ASSERT(a_fe_read_wait, accept |=> !i_pix.ready, "pixel taken before row store read settled")
    `R2Y_ASSERT(a_fe_pend_src, $rose(r_pend) |-> $past(accept), "chroma job raised without a pixel")
    `R2Y_ASSERT(a_fe_cnt_range, (DIM_W'(r_col) < r_wid) && (DIM_W'(r_row) < r_hgt), "position counter outside frame")

endmodule

`default_nettype wire

[src/r2y_back.sv]
// Back end: matrix pipeline that turns queued jobs into luma or Cb/Cr results,
// with an output register that splits chroma jobs into two beats.
// Depends on r2y_pkg, the result interface and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module r2y_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    output logic          o_pop,
    input  r2y_pkg::t_job i_job,
    input  logic          i_empty,
    r2y_res_if.source     o_res
);
    import r2y_pkg::*;

    logic                    r1_valid;
    t_meta                   r1_meta;
    logic [LUM_W-1:0]        r1_lum;
    logic [SUM_W-1:0]        r1_r;
    logic [SUM_W-1:0]        r1_b;
    logic                    r2_valid;
    t_meta                   r2_meta;
    logic [YP_W-1:0]         r2_ypr;
    logic signed [D_W-1:0]   r2_db;
    logic signed [D_W-1:0]   r2_dr;
    logic                    r3_valid;
    t_meta                   r3_meta;
    logic [VAL_W-1:0]        r3_y;
    logic signed [P_W-1:0]   r3_pb;
    logic signed [P_W-1:0]   r3_pr;
    logic                    r_out_valid;
    t_res                    r_out;
    logic                    r_cr_pend;
    t_res                    r_cr;

    logic                    o_free;
    logic                    load_cr;
    logic                    load_s3;
    logic                    adv;
    logic [LUM_W-1:0]        n_lum;
    t_res                    y_res;
    t_res                    cb_res;
    t_res                    cr_res;

    always_comb begin
        o_free  = !r_out_valid || o_res.ready;
        load_cr = o_free && r_cr_pend;
        load_s3 = o_free && !r_cr_pend && r3_valid;
        adv     = !r3_valid || load_s3;
        o_pop   = adv && !i_empty;

        n_lum = LUM_W'(i_job.s.r) * KR + LUM_W'(i_job.s.g) * KG + LUM_W'(i_job.s.b) * KB;

        y_res.plane_sel    = PLANE_Y;
        y_res.sample_value = r3_y;
        y_res.pos_x        = r3_meta.pos_x;
        y_res.pos_y        = r3_meta.pos_y;
        y_res.last_of_item = r3_meta.last;
        y_res.frame_done   = r3_meta.done;

        cb_res.plane_sel    = PLANE_CB;
        cb_res.sample_value = chroma_val(r3_pb);
        cb_res.pos_x        = r3_meta.pos_x;
        cb_res.pos_y        = r3_meta.pos_y;
        cb_res.last_of_item = 1'b0;
        cb_res.frame_done   = 1'b0;

        cr_res.plane_sel    = PLANE_CR;
        cr_res.sample_value = chroma_val(r3_pr);
        cr_res.pos_x        = r3_meta.pos_x;
        cr_res.pos_y        = r3_meta.pos_y;
        cr_res.last_of_item = 1'b1;
        cr_res.frame_done   = r3_meta.done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r_out_valid <= 1'b0;
            r_cr_pend   <= 1'b0;
        end else begin
            if (adv) begin
                r1_valid <= o_pop;
                r2_valid <= r1_valid;
                r3_valid <= r2_valid;
            end
            if (load_cr) begin
                r_cr_pend   <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (load_s3) begin
                r_cr_pend   <= r3_meta.is_chroma;
                r_out_valid <= 1'b1;
            end else if (o_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_meta <= i_job.meta;
            r1_lum  <= n_lum;
            r1_r    <= i_job.s.r;
            r1_b    <= i_job.s.b;
            r2_meta <= r1_meta;
            r2_ypr  <= YP_W'(r1_lum) * KY;
            r2_db   <= $signed({1'b0, r1_b, 16'h0000}) - $signed({1'b0, r1_lum});
            r2_dr   <= $signed({1'b0, r1_r, 16'h0000}) - $signed({1'b0, r1_lum});
            r3_meta <= r2_meta;
            r3_y    <= luma_val(r2_ypr);
            r3_pb   <= P_W'(r2_db) * P_W'(KCB);
            r3_pr   <= P_W'(r2_dr) * P_W'(KCR);
        end
        if (load_cr) begin
            r_out <= r_cr;
        end else if (load_s3) begin
            r_out <= r3_meta.is_chroma ? cb_res : y_res;
            r_cr  <= cr_res;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.plane_sel    = r_out.plane_sel;
    assign o_res.sample_value = r_out.sample_value;
    assign o_res.pos_x        = r_out.pos_x;
    assign o_res.pos_y        = r_out.pos_y;
    assign o_res.last_of_item = r_out.last_of_item;
    assign o_res.frame_done   = r_out.frame_done;

    `R2Y_ASSERT(a_be_cr_behind_cb, r_cr_pend |-> r_out_valid, "Cr pending without a Cb beat shown")
    `R2Y_ASSERT(a_be_cr_next, $fell(r_cr_pend) |-> (r_out_valid && r_out.plane_sel == PLANE_CR), "Cr beat did not follow Cb")
    `R2Y_ASSERT(a_be_s3_hold, (r3_valid && !adv) |=> r3_valid, "stalled job lost from last stage")

endmodule

`default_nettype wire

[src/rgb_to_yuv420_rec709.sv]
// Top level of the RGB to Rec.709 limited-range YCbCr 4:2:0 converter.
// Depends on r2y_pkg, the three channel interfaces, r2y_front, r2y_queue and r2y_back.
`default_nettype none

// Pixels enter in raster order on i_pix; every pixel gives one luma beat on o_res, and
// odd-column pixels of odd rows add a Cb beat and a Cr beat (left-sited 4:2:0). After
// each pixel the block does not take the next one until the column counter has advanced
// and the even-row store, a memory with registered read, presents the next column's
// entry; on chroma pixels it also waits until the chroma job is pushed into the 4-entry
// queue. The back end runs a 3-stage matrix pipeline and shows one beat per cycle while
// the sink is ready, so a chroma job holds it for a Cb beat and then a Cr beat; a luma job
// passes through the queue, the pipeline stages and the output register.
// Writing frame_width or frame_height restarts the frame; sizes are clamped to
// [2, min(MAX_WIDTH, 4096)] and [2, 4096] and rounded down to even. The row store is not
// cleared after reset; the first row of every frame fills it before it is read.
module rgb_to_yuv420_rec709 #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    r2y_pix_if.sink   i_pix,
    r2y_cfg_if.sink   i_cfg,
    r2y_res_if.source o_res
);
    import r2y_pkg::*;

    logic push;
    logic pop;
    logic full;
    logic empty;
    t_job push_job;
    t_job pop_job;

    r2y_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (i_pix),
        .i_cfg   (i_cfg),
        .o_push  (push),
        .o_job   (push_job),
        .i_full  (full)
    );

    r2y_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (pop_job),
        .o_empty (empty)
    );

    r2y_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .o_pop   (pop),
        .i_job   (pop_job),
        .i_empty (empty),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for rgb_to_yuv420_rec709: streams RGB pixels over several frame
// sizes and pacing modes and compares every Y/Cb/Cr beat with an in-bench predictor.
// Depends on r2y_pkg, r2y_pix_if, r2y_cfg_if, r2y_res_if and the converter RTL.

module testbench;
    import r2y_pkg::*;

    localparam int  CLK_HALF   = 5;
    localparam int  CYCLE_CAP  = 1000000;
    localparam int  SETTLE     = 16;
    localparam int  LINE_DEPTH = 4096;
    localparam longint W_RED   = 13933;
    localparam longint W_GREEN = 46871;
    localparam longint W_BLUE  = 4732;
    localparam longint CB_GAIN = 7911222;
    localparam longint CR_GAIN = 9321859;
    localparam logic [IDX_W-1:0] REG_SPARE = IDX_W'(2);

    typedef enum int {PACE_FULL, PACE_SRC_IDLE, PACE_SNK_STALL, PACE_BOTH} t_pace;

    typedef struct {
        logic signed [IN_W-1:0] r;
        logic signed [IN_W-1:0] g;
        logic signed [IN_W-1:0] b;
    } t_pixel;

    logic i_clk = 1'b0;
    logic i_rst_n;

    r2y_pix_if pix_bus ();
    r2y_cfg_if cfg_bus ();
    r2y_res_if res_bus ();

    rgb_to_yuv420_rec709 DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_bus),
        .i_cfg   (cfg_bus),
        .o_res   (res_bus)
    );

    // converter image
    t_rgb        even_row [LINE_DEPTH];
    t_rgb        prev_px;
    t_rgb        prev2_px;
    int unsigned col_pos;
    int unsigned row_pos;
    int unsigned width_reg;
    int unsigned height_reg;

    t_res   pending_samples[$];
    t_pixel pixel_queue[$];
    t_pixel next_px;
    t_pace  pace;
    logic   pix_taken;
    int     error_count;
    int     cycle_count;

    always #CLK_HALF i_clk = ~i_clk;

    function automatic logic [CH_W-1:0] clamp_channel(input logic signed [IN_W-1:0] v);
        logic [CH_W-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > CH_ONE) begin
            res = CH_W'(CH_ONE);
        end else begin
            res = CH_W'(v);
        end
        return res;
    endfunction

    function automatic int unsigned size_limit(input int unsigned v, input int unsigned hi);
        int unsigned t;
        t = (v < 2) ? 2 : v;
        t = (t > hi) ? hi : t;
        return t & ~32'd1;
    endfunction

    function automatic longint weighted_luma(input longint r, input longint g, input longint b);
        return W_RED * r + W_GREEN * g + W_BLUE * b;
    endfunction

    function automatic logic [VAL_W-1:0] luma_code(input longint lum);
        longint y;
        y = 16 + ((219 * lum) >>> (16 + FRAC_BITS));
        return (y > 255) ? VAL_W'(255) : VAL_W'(y);
    endfunction

    function automatic logic [VAL_W-1:0] chroma_code(input longint base, input longint lum,
                                                     input longint gain);
        longint t;
        longint v;
        logic [VAL_W-1:0] res;
        t = (longint'(128) <<< (32 + FRAC_BITS + 3)) + ((base <<< 16) - lum) * gain;
        v = t >>> (32 + FRAC_BITS + 3);
        if (t < 0) begin
            res = '0;
        end else if (v > 255) begin
            res = VAL_W'(255);
        end else begin
            res = VAL_W'(v);
        end
        return res;
    endfunction

    function automatic longint tap_sum(input logic [CH_W-1:0] e0, input logic [CH_W-1:0] e1,
                                       input logic [CH_W-1:0] e2, input logic [CH_W-1:0] o0,
                                       input logic [CH_W-1:0] o1, input logic [CH_W-1:0] o2);
        return longint'(e0) + 2 * longint'(e1) + longint'(e2)
             + longint'(o0) + 2 * longint'(o1) + longint'(o2);
    endfunction

    function automatic void apply_reg(input logic [IDX_W-1:0] idx,
                                      input logic [DIM_W-1:0] val);
        if (idx == REG_FRAME_WIDTH) begin
            width_reg = val;
        end else if (idx == REG_FRAME_HEIGHT) begin
            height_reg = val;
        end else begin
            return;
        end
        col_pos = 0;
        row_pos = 0;
    endfunction

    // Expected Y, then Cb and Cr on odd columns of odd rows.
    function automatic void convert_pixel(input t_pixel px);
        int unsigned w, h, x, y, c, cl;
        bit          chroma, last_px;
        t_rgb        cur, e0, e1, e2, o0;
        longint      sr, sg, sb, lum;
        t_res        beat;
        w = size_limit(width_reg, LINE_DEPTH);
        h = size_limit(height_reg, 4096);
        x = col_pos;
        y = row_pos;
        cur.r = clamp_channel(px.r);
        cur.g = clamp_channel(px.g);
        cur.b = clamp_channel(px.b);
        chroma  = ((y & 1) != 0) && ((x & 1) != 0);
        last_px = (x + 1 >= w) && (y + 1 >= h);
        if (x >= w || y >= h) begin
            x = 0;
            y = 0;
            chroma = 0;
            last_px = 0;
        end

        beat.plane_sel    = PLANE_Y;
        beat.sample_value = luma_code(weighted_luma(cur.r, cur.g, cur.b));
        beat.pos_x        = POS_W'(x);
        beat.pos_y        = POS_W'(y);
        beat.last_of_item = !chroma;
        beat.frame_done   = !chroma && last_px;
        pending_samples.push_back(beat);

        if (chroma) begin
            c  = x - 1;
            cl = (c == 0) ? 0 : c - 1;
            e0 = even_row[cl];
            e1 = even_row[c];
            e2 = even_row[x];
            o0 = (c == 0) ? prev_px : prev2_px;
            sr = tap_sum(e0.r, e1.r, e2.r, o0.r, prev_px.r, cur.r);
            sg = tap_sum(e0.g, e1.g, e2.g, o0.g, prev_px.g, cur.g);
            sb = tap_sum(e0.b, e1.b, e2.b, o0.b, prev_px.b, cur.b);
            lum = weighted_luma(sr, sg, sb);
            beat.plane_sel    = PLANE_CB;
            beat.sample_value = chroma_code(sb, lum, CB_GAIN);
            beat.pos_x        = POS_W'(c >> 1);
            beat.pos_y        = POS_W'(y >> 1);
            beat.last_of_item = 1'b0;
            beat.frame_done   = 1'b0;
            pending_samples.push_back(beat);
            beat.plane_sel    = PLANE_CR;
            beat.sample_value = chroma_code(sr, lum, CR_GAIN);
            beat.last_of_item = 1'b1;
            beat.frame_done   = last_px;
            pending_samples.push_back(beat);
        end

        if ((y & 1) == 0 && x < LINE_DEPTH) begin
            even_row[x] = cur;
        end
        prev2_px = prev_px;
        prev_px  = cur;
        if (x + 1 >= w) begin
            col_pos = 0;
            row_pos = (y + 1 >= h) ? 0 : y + 1;
        end else begin
            col_pos = x + 1;
            row_pos = y;
        end
    endfunction

    function automatic logic signed [IN_W-1:0] random_channel();
        logic signed [IN_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = IN_W'($urandom);
            1: v = '0;
            2: v = IN_W'(CH_ONE);
            3: v = IN_W'($urandom_range(CH_ONE + 1, 32767));
            4: v = -IN_W'($urandom_range(1, 32768));
            default: v = IN_W'($urandom_range(0, CH_ONE));
        endcase
        return v;
    endfunction

    function automatic t_pixel make_px(input int r, input int g, input int b);
        t_pixel px;
        px.r = IN_W'(r);
        px.g = IN_W'(g);
        px.b = IN_W'(b);
        return px;
    endfunction

    function automatic void queue_random(input int n);
        repeat (n) begin
            pixel_queue.push_back(make_px(random_channel(), random_channel(),
                                          random_channel()));
        end
    endfunction

    function automatic bit idle_roll(input bit side_src);
        bit hit;
        hit = 0;
        case (pace)
            PACE_SRC_IDLE:  hit = side_src && ($urandom_range(0, 99) < 87);
            PACE_SNK_STALL: hit = !side_src && ($urandom_range(0, 99) < 87);
            PACE_BOTH:      hit = $urandom_range(0, 99) < 38;
            default:        hit = 0;
        endcase
        return hit;
    endfunction

    // pixel source
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pix_bus.valid <= 1'b0;
        end else if (!pix_bus.valid || pix_taken) begin
            if (pixel_queue.size() != 0 && !idle_roll(1'b1)) begin
                next_px = pixel_queue.pop_front();
                pix_bus.valid    <= 1'b1;
                pix_bus.red_in   <= next_px.r;
                pix_bus.green_in <= next_px.g;
                pix_bus.blue_in  <= next_px.b;
            end else begin
                pix_bus.valid <= 1'b0;
            end
        end
    end

    // result sink
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
        end else begin
            res_bus.ready <= !idle_roll(1'b0);
        end
    end

    always @(posedge i_clk) begin
        pix_taken <= pix_bus.valid && pix_bus.ready;
        if (i_rst_n && pix_bus.valid && pix_bus.ready) begin
            convert_pixel(make_px(pix_bus.red_in, pix_bus.green_in, pix_bus.blue_in));
        end
    end

    always @(posedge i_clk) begin : check_samples
        t_res want;
        t_res got;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            got.plane_sel    = t_plane'(res_bus.plane_sel);
            got.sample_value = res_bus.sample_value;
            got.pos_x        = res_bus.pos_x;
            got.pos_y        = res_bus.pos_y;
            got.last_of_item = res_bus.last_of_item;
            got.frame_done   = res_bus.frame_done;
            if (pending_samples.size() == 0) begin
                error_count++;
                $display("%0t: unexpected beat plane=%0d val=%0d x=%0d y=%0d last=%0b done=%0b",
                         $time, got.plane_sel, got.sample_value, got.pos_x, got.pos_y,
                         got.last_of_item, got.frame_done);
            end else begin
                want = pending_samples.pop_front();
                if (got.plane_sel !== want.plane_sel || got.sample_value !== want.sample_value
                    || got.pos_x !== want.pos_x || got.pos_y !== want.pos_y
                    || got.last_of_item !== want.last_of_item
                    || got.frame_done !== want.frame_done) begin
                    error_count++;
                    $display("%0t: mismatch exp plane=%0d val=%0d x=%0d y=%0d last=%0b done=%0b",
                             $time, want.plane_sel, want.sample_value, want.pos_x, want.pos_y,
                             want.last_of_item, want.frame_done);
                    $display("%0t:          got plane=%0d val=%0d x=%0d y=%0d last=%0b done=%0b",
                             $time, got.plane_sel, got.sample_value, got.pos_x, got.pos_y,
                             got.last_of_item, got.frame_done);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        apply_reg(idx, val);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic drain();
        while (pixel_queue.size() != 0 || pix_bus.valid || pending_samples.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic run_frames(input int w, input int h, input t_pace p, input int n);
        write_reg(REG_FRAME_WIDTH, DIM_W'(w));
        write_reg(REG_FRAME_HEIGHT, DIM_W'(h));
        pace = p;
        queue_random(n);
        drain();
    endtask

    initial begin
        i_rst_n          = 1'b0;
        pix_bus.valid    = 1'b0;
        pix_bus.red_in   = '0;
        pix_bus.green_in = '0;
        pix_bus.blue_in  = '0;
        cfg_bus.valid    = 1'b0;
        cfg_bus.index    = '0;
        cfg_bus.data     = '0;
        res_bus.ready    = 1'b0;
        pix_taken        = 1'b0;
        error_count      = 0;
        cycle_count      = 0;
        pace             = PACE_FULL;
        prev_px          = '0;
        prev2_px         = '0;
        col_pos          = 0;
        row_pos          = 0;
        width_reg        = 1920;
        height_reg       = 1080;

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset frame size, first row only
        queue_random(8);
        drain();

        // 4x4 directed frame plus the start of the next one
        write_reg(REG_FRAME_WIDTH, DIM_W'(4));
        write_reg(REG_FRAME_HEIGHT, DIM_W'(4));
        pixel_queue.push_back(make_px(0, 0, 0));
        pixel_queue.push_back(make_px(CH_ONE, CH_ONE, CH_ONE));
        pixel_queue.push_back(make_px(CH_ONE, 0, 0));
        pixel_queue.push_back(make_px(0, CH_ONE, 0));
        pixel_queue.push_back(make_px(0, 0, CH_ONE));
        pixel_queue.push_back(make_px(-32768, -1, 32767));
        pixel_queue.push_back(make_px(CH_ONE, 0, 0));
        pixel_queue.push_back(make_px(0, 0, CH_ONE));
        pixel_queue.push_back(make_px(32767, 32767, 32767));
        pixel_queue.push_back(make_px(-32768, -32768, -32768));
        pixel_queue.push_back(make_px(CH_ONE + 1, CH_ONE - 1, 1));
        pixel_queue.push_back(make_px(-1, 2048, CH_ONE));
        pixel_queue.push_back(make_px(21845, -21846, 2730));
        pixel_queue.push_back(make_px(0, CH_ONE, CH_ONE));
        pixel_queue.push_back(make_px(CH_ONE, CH_ONE, 0));
        pixel_queue.push_back(make_px(CH_ONE, 0, CH_ONE));
        pixel_queue.push_back(make_px(CH_ONE, CH_ONE, CH_ONE));
        pixel_queue.push_back(make_px(0, 0, 0));
        pixel_queue.push_back(make_px(1, 1, 1));
        pixel_queue.push_back(make_px(CH_ONE - 1, CH_ONE - 1, CH_ONE - 1));
        drain();

        run_frames(2, 2, PACE_SRC_IDLE, 40);
        run_frames(0, 1, PACE_SNK_STALL, 20);
        run_frames(7, 5, PACE_BOTH, 40);
        run_frames(8191, 2, PACE_FULL, 16);
        run_frames(16, 8191, PACE_BOTH, 80);

        // unused index must leave size and position alone
        write_reg(REG_FRAME_WIDTH, DIM_W'(10));
        write_reg(REG_FRAME_HEIGHT, DIM_W'(6));
        pace = PACE_SRC_IDLE;
        queue_random(25);
        drain();
        write_reg(REG_SPARE, DIM_W'($urandom));
        queue_random(35);
        drain();

        for (int k = 0; k < 4; k++) begin
            run_frames($urandom_range(2, 24), $urandom_range(2, 12), t_pace'(k), 30);
        end

        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
